[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tcse_pkg.sv]
// ---------------------------------------------------------------------------
// tcse_pkg
// Types and constants for toric-code syndrome extraction.
// ---------------------------------------------------------------------------
package tcse_pkg;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  localparam int unsigned SIDE_W    = 6;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd7;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 6'd2;

  typedef struct packed {
    logic       req_type;
    logic       layer;
    logic [4:0] col;
    logic [4:0] row;
    logic       z_flip;
    logic       x_flip;
  } req_t;

  typedef struct packed {
    logic       stab_layer;
    logic [4:0] stab_col;
    logic [4:0] stab_row;
    logic       syndrome_bit;
    logic       out_of_range;
  } rsp_t;

endpackage

[rtl/toric_code_syndrome_extraction.sv]
// ---------------------------------------------------------------------------
// toric_code_syndrome_extraction
// Error store for a periodic toric-code lattice with stabilizer readout.
// ---------------------------------------------------------------------------
// The block holds a Z-error and an X-error bit for every qubit of a wrapping
// lattice of two layers (horizontal edges on layer 0, vertical edges on
// layer 1) in one single-port synchronous memory of 2*MAX_SIDE*MAX_SIDE
// two-bit entries. A write request sets one qubit's bits and yields no
// response; a write outside the configured grid is dropped. A read request
// names a vertex (layer 0) or plaquette (layer 1) stabilizer and yields one
// response with the parity of the four neighboring qubits, Z bits for a
// vertex and X bits for a plaquette, coordinates wrapping by the grid size.
// A read outside the configured grid returns out_of_range set and a zero
// syndrome. Requests are handled one at a time: a write passes through
// accept and memory write; an in-range read through accept, four memory
// reads through the one port and final parity, an out-of-range read
// through accept and final response. The one memory port serializes reads.
// A finished response waits in an output register, so the next request is
// accepted while the response is still stalled. After reset the block runs a
// clearing pass over all 2*MAX_SIDE*MAX_SIDE entries (2048 at the default size)
// with the request side stalled; configuration writes are taken throughout.
// Grid width and height are APB registers at byte addresses 0 and 4, each
// saturated to 2..MAX_SIDE when used.
// ---------------------------------------------------------------------------
module toric_code_syndrome_extraction #(
  parameter int MAX_SIDE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcse_pkg::req_t    in_req_i,
  // response channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcse_pkg::rsp_t    out_rsp_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tcse_pkg::*;

  localparam int DEPTH     = 2 * MAX_SIDE * MAX_SIDE;
  localparam int LAYER_OFS = MAX_SIDE * MAX_SIDE;
  localparam int AW        = $clog2(DEPTH);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WRITE  = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // Clamp a size register to the supported range.
  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] r);
    if (r < SIDE_MIN) return SIDE_MIN;
    if (32'(r) > MAX_SIDE) return SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  // Flat store address: layer plane, then row, then column.
  function automatic logic [AW-1:0] addr_of(input logic lay,
                                            input logic [SIDE_W-1:0] r,
                                            input logic [SIDE_W-1:0] c);
    int a;
    a = int'(lay) * LAYER_OFS + int'(r) * MAX_SIDE + int'(c);
    return AW'(a);
  endfunction

  // ---- configuration registers ----
  logic [SIDE_W-1:0] grid_width_q, grid_height_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= SIDE_RESET;
      grid_height_q <= SIDE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[SIDE_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[SIDE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GRID_WIDTH:  prdata = {{(32-SIDE_W){1'b0}}, grid_width_q};
      REG_GRID_HEIGHT: prdata = {{(32-SIDE_W){1'b0}}, grid_height_q};
    endcase
  end

  logic [SIDE_W-1:0] width_use, height_use;
  assign width_use  = sat_side(grid_width_q);
  assign height_use = sat_side(grid_height_q);

  // ---- control state ----
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          acc_q, acc_d;
  logic          rd_vld_q;
  logic          oor_q, oor_d;
  req_t          req_q, req_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_rsp_q, out_rsp_d;

  logic          in_acc;
  logic          in_oor;
  logic          out_free;
  logic          syn_next;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  // Flag coordinates at or past the grid in use.
  assign in_oor = ({1'b0, in_req_i.col} >= width_use) ||
                  ({1'b0, in_req_i.row} >= height_use);

  // ---- neighbor coordinates, wrapped by the grid in use ----
  logic [SIDE_W-1:0] x6, y6, xm6, ym6, xp6, yp6;
  assign x6  = {1'b0, req_q.col};
  assign y6  = {1'b0, req_q.row};
  assign xm6 = (x6 == '0) ? width_use - 6'd1 : x6 - 6'd1;
  assign ym6 = (y6 == '0) ? height_use - 6'd1 : y6 - 6'd1;
  assign xp6 = (x6 + 6'd1 == width_use) ? '0 : x6 + 6'd1;
  assign yp6 = (y6 + 6'd1 == height_use) ? '0 : y6 + 6'd1;

  // Pick the qubit for this read step: vertex walks h left, h, v up, v;
  // plaquette walks v, v right, h, h down.
  logic              rd_lay;
  logic [SIDE_W-1:0] rd_row, rd_col;
  always_comb begin
    rd_lay = 1'b0;
    rd_row = y6;
    rd_col = x6;
    if (req_q.layer == 1'b0) begin
      case (cnt_q)
        2'd0: begin rd_lay = 1'b0; rd_col = xm6; end
        2'd1: begin rd_lay = 1'b0; end
        2'd2: begin rd_lay = 1'b1; rd_row = ym6; end
        default: begin rd_lay = 1'b1; end
      endcase
    end else begin
      case (cnt_q)
        2'd0: begin rd_lay = 1'b1; end
        2'd1: begin rd_lay = 1'b1; rd_col = xp6; end
        2'd2: begin rd_lay = 1'b0; end
        default: begin rd_lay = 1'b0; rd_row = yp6; end
      endcase
    end
  end

  // ---- error store ----
  logic [1:0]    error_mem [DEPTH];
  logic [1:0]    rdata_q;
  logic [AW-1:0] mem_addr;
  logic [1:0]    mem_wdata;
  logic          mem_we, mem_re;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '0;
    mem_addr  = addr_of(rd_lay, rd_row, rd_col);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      ST_WRITE: begin
        mem_we    = ~oor_q;
        mem_wdata = {req_q.x_flip, req_q.z_flip};
        mem_addr  = addr_of(req_q.layer, y6, x6);
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      error_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= error_mem[mem_addr];
    end
  end

  // Fold in the returning bit: Z (bit 0) for a vertex, X (bit 1) for a
  // plaquette, which is the stabilizer layer itself.
  assign syn_next = acc_q ^ (rd_vld_q & rdata_q[req_q.layer]);

  // ---- sequencer ----
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    acc_d       = syn_next;
    oor_d       = oor_q;
    req_d       = req_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_rsp_d   = out_rsp_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        acc_d = 1'b0;
        if (in_acc) begin
          req_d = in_req_i;
          oor_d = in_oor;
          cnt_d = '0;
          if (in_req_i.req_type == REQ_WRITE) begin
            state_d = ST_WRITE;
          end else if (in_oor) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      ST_READ: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register can take the response.
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_rsp_d.stab_layer   = req_q.layer;
          out_rsp_d.stab_col     = req_q.col;
          out_rsp_d.stab_row     = req_q.row;
          out_rsp_d.syndrome_bit = oor_q ? 1'b0 : syn_next;
          out_rsp_d.out_of_range = oor_q;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      acc_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      rd_vld_q    <= mem_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    oor_q     <= oor_d;
    out_rsp_q <= out_rsp_d;
  end

endmodule

[rtl/tcse_checker.sv]
// ---------------------------------------------------------------------------
// tcse_checker
// Port-level checks for toric-code syndrome extraction.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcse_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tcse_pkg::rsp_t out_rsp_o
);
  import tcse_pkg::*;

  `ASSERT_CLK_RST(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o), "stalled response changed")

  `ASSERT_CLK_RST(a_oor_zero, clk_i, rst_ni, out_valid_o && out_rsp_o.out_of_range |-> !out_rsp_o.syndrome_bit, "out-of-range response carries a syndrome")

  `ASSERT_CLK_RST(a_rsp_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "response appeared while idle")

  `ASSERT_CLK_RST(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "second request taken before the first finished")

  `ASSERT_CLK(a_stall_in_reset, clk_i, !rst_ni |-> in_stall_o, "requests taken during reset")

endmodule

bind toric_code_syndrome_extraction tcse_checker u_tcse_checker (.*);

[tb/tcse_syndrome_checker.sv]
// ---------------------------------------------------------------------------
// tcse_syndrome_checker
// Watches the request, response and configuration traffic of the syndrome
// extraction block, keeps its own copy of the qubit error store and grid
// size, predicts every stabilizer response and compares it field by field.
// ---------------------------------------------------------------------------
module tcse_syndrome_checker
  import tcse_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  req_t            in_req_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  rsp_t            out_rsp_i,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic            pready,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output int unsigned     pending_o,
  output int unsigned     mismatch_count_o
);

  localparam int unsigned MAX_SIDE = 32;
  localparam logic        LAYER_H  = 1'b0;  // horizontal edges, vertex reads
  localparam logic        LAYER_V  = 1'b1;  // vertical edges, plaquette reads
  localparam int unsigned Z_BIT    = 0;
  localparam int unsigned X_BIT    = 1;

  logic [1:0]  qubit_err [0:2*MAX_SIDE*MAX_SIDE-1];
  logic [5:0]  width_reg;
  logic [5:0]  height_reg;
  rsp_t        syndrome_due [$];
  int unsigned mismatches;

  function automatic int unsigned side_used(logic [5:0] v);
    if (v < SIDE_MIN) return SIDE_MIN;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic logic err_at(logic lay, int unsigned r, int unsigned c,
                                  int unsigned which);
    logic [10:0] idx;
    idx = {lay, 5'(r), 5'(c)};
    return qubit_err[idx][which];
  endfunction

  function automatic rsp_t predict_syndrome(req_t rq);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    rsp_t        rs;
    w = side_used(width_reg);
    h = side_used(height_reg);
    x = rq.col;
    y = rq.row;
    rs.stab_layer   = rq.layer;
    rs.stab_col     = rq.col;
    rs.stab_row     = rq.row;
    rs.out_of_range = (x >= w) || (y >= h);
    rs.syndrome_bit = 1'b0;
    if (!rs.out_of_range) begin
      if (rq.layer == LAYER_H) begin
        rs.syndrome_bit = err_at(LAYER_H, y, (x + w - 1) % w, Z_BIT)
                        ^ err_at(LAYER_H, y, x, Z_BIT)
                        ^ err_at(LAYER_V, (y + h - 1) % h, x, Z_BIT)
                        ^ err_at(LAYER_V, y, x, Z_BIT);
      end else begin
        rs.syndrome_bit = err_at(LAYER_V, y, x, X_BIT)
                        ^ err_at(LAYER_V, y, (x + 1) % w, X_BIT)
                        ^ err_at(LAYER_H, y, x, X_BIT)
                        ^ err_at(LAYER_H, (y + 1) % h, x, X_BIT);
      end
    end
    return rs;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 2*MAX_SIDE*MAX_SIDE; i++) qubit_err[i] = '0;
      width_reg  = SIDE_RESET;
      height_reg = SIDE_RESET;
      syndrome_due.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_GRID_WIDTH:  width_reg  = pwdata[5:0];
          REG_GRID_HEIGHT: height_reg = pwdata[5:0];
          default: ;
        endcase
      end
      // Responses first: nothing accepted at this edge can answer at it.
      if (out_valid_i && !out_stall_i) begin
        if (syndrome_due.size() == 0) begin
          $error("unexpected response: layer %0d col %0d row %0d",
                 out_rsp_i.stab_layer, out_rsp_i.stab_col, out_rsp_i.stab_row);
          mismatches++;
        end else begin
          want = syndrome_due.pop_front();
          check_field("stab_layer",   want.stab_layer,   out_rsp_i.stab_layer);
          check_field("stab_col",     want.stab_col,     out_rsp_i.stab_col);
          check_field("stab_row",     want.stab_row,     out_rsp_i.stab_row);
          check_field("syndrome_bit", want.syndrome_bit, out_rsp_i.syndrome_bit);
          check_field("out_of_range", want.out_of_range, out_rsp_i.out_of_range);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.req_type == REQ_READ) begin
          syndrome_due.insert(syndrome_due.size(), predict_syndrome(in_req_i));
        end else if (in_req_i.col < side_used(width_reg) &&
                     in_req_i.row < side_used(height_reg)) begin
          qubit_err[{in_req_i.layer, in_req_i.row, in_req_i.col}] =
            {in_req_i.x_flip, in_req_i.z_flip};
        end
      end
    end
    pending_o        <= syndrome_due.size();
    mismatch_count_o <= mismatches;
  end

endmodule

[tb/tb_toric_code_syndrome_extraction.sv]
// ---------------------------------------------------------------------------
// tb_toric_code_syndrome_extraction
// Stimulus and verdict for the toric-code syndrome extraction block.
// ---------------------------------------------------------------------------
// A directed burst at the reset grid size checks a clean store, lattice
// wrap in both directions for vertex and plaquette stabilizers, overwrites
// and out-of-range reads and writes. Random phases follow, each at its own
// grid size (including values that saturate low and high) and its own idle
// pattern on the two channels. Random requests cluster around a wandering
// hot spot so stabilizers actually see errors on large grids. Prediction and
// comparison live in tcse_syndrome_checker; this module drives and judges.
// ---------------------------------------------------------------------------
module tb_toric_code_syndrome_extraction;
  import tcse_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  // Settling time after draining; give the block ample room to go idle.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic        LAYER_H       = 1'b0;  // write: horizontal edge
  localparam logic        LAYER_V       = 1'b1;  // write: vertical edge
  localparam logic        KIND_VERTEX   = 1'b0;  // read: vertex stabilizer
  localparam logic        KIND_PLAQ     = 1'b1;  // read: plaquette stabilizer

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  req_t        in_req_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_count   = 0;
  // Response side pattern, handed to the receiver process by nonblocking
  // writes so the hand-over never races with its falling-edge update.
  int unsigned rsp_stall_pct = 0;
  int unsigned hold_len      = 0;
  int unsigned hold_seq      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  // Request side pattern and grid size in use, for stimulus shaping only.
  int unsigned req_idle_pct  = 0;
  int unsigned width_used    = SIDE_RESET;
  int unsigned height_used   = SIDE_RESET;
  int unsigned spot_col      = 0;
  int unsigned spot_row      = 0;

  toric_code_syndrome_extraction i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tcse_syndrome_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_req_i         (in_req_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_rsp_i        (out_rsp_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pending_o        (pending),
    .mismatch_count_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: anything still owed at this point counts as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_toric_code_syndrome_extraction: done, errors");
      $finish;
    end
  end

  // Receiver: a requested long hold wins over the random stall pattern.
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= hold_len;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  function automatic int unsigned side_of(logic [31:0] v);
    if (v[5:0] < SIDE_MIN) return SIDE_MIN;
    if (v[5:0] > 32) return 32;
    return v[5:0];
  endfunction

  function automatic req_t qubit_req(logic kind, logic lay, int unsigned c,
                                     int unsigned r, logic zf, logic xf);
    req_t q;
    q.req_type = kind;
    q.layer    = lay;
    q.col      = 5'(c);
    q.row      = 5'(r);
    q.z_flip   = zf;
    q.x_flip   = xf;
    return q;
  endfunction

  // Two-phase APB write; call at a falling edge, returns at one.
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Step past the release so back-to-back writes never double-drive psel.
    @(negedge clk_i);
    if (idx == REG_GRID_WIDTH) width_used = side_of(val);
    else height_used = side_of(val);
  endtask

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_req(input req_t q);
    while ($urandom_range(99) < req_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop offering, wait for every owed response, then let a trailing
  // write retire before anything else touches the block.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Mostly in-range requests near a hot spot, some anywhere in the field.
  task automatic pick_request(output req_t q);
    int unsigned c;
    int unsigned r;
    if ($urandom_range(99) < 8) begin
      spot_col = $urandom_range(width_used - 1);
      spot_row = $urandom_range(height_used - 1);
    end
    spot_col = spot_col % width_used;
    spot_row = spot_row % height_used;
    if ($urandom_range(99) < 12) begin
      c = $urandom_range(31);
      r = $urandom_range(31);
    end else if ($urandom_range(99) < 65) begin
      c = (spot_col + width_used + $urandom_range(2) - 1) % width_used;
      r = (spot_row + height_used + $urandom_range(2) - 1) % height_used;
    end else begin
      c = $urandom_range(width_used - 1);
      r = $urandom_range(height_used - 1);
    end
    q = qubit_req(($urandom_range(99) < 55) ? REQ_READ : REQ_WRITE,
                  1'($urandom_range(1)), c, r,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic run_phase(input logic [31:0] w_val, input logic [31:0] h_val,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_items, input bit with_hold);
    int unsigned sent;
    bit          held;
    req_t        q;
    drain();
    cfg_write(REG_GRID_WIDTH, w_val);
    cfg_write(REG_GRID_HEIGHT, h_val);
    req_idle_pct  = idle_pct;
    rsp_stall_pct <= stall_pct;
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      // Long receiver hold while requests keep coming: fill the block up.
      if (with_hold && !held && sent >= n_items / 4) begin
        hold_len <= HOLD_CYCLES;
        hold_seq <= hold_seq + 1;
        held = 1'b1;
      end
      pick_request(q);
      send_req(q);
      // Dropped out-of-range writes do not count toward the phase.
      if (!(q.req_type == REQ_WRITE && (q.col >= width_used || q.row >= height_used)))
        sent++;
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_req_i   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_ni     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed burst at the reset size of 7 by 7, no idling. The block's
    // clearing pass after reset simply shows up as a stalled first request.
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 0, 0, 1'b0, 1'b0));  // clean store
    send_req(qubit_req(REQ_WRITE, LAYER_H,     0, 0, 1'b1, 1'b1));
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 0, 0, 1'b0, 1'b0));
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 1, 0, 1'b0, 1'b0));  // left neighbor
    send_req(qubit_req(REQ_WRITE, LAYER_H,     6, 2, 1'b1, 1'b0));
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 0, 2, 1'b0, 1'b0));  // column wraps left
    send_req(qubit_req(REQ_WRITE, LAYER_V,     3, 6, 1'b1, 1'b0));
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 3, 0, 1'b0, 1'b0));  // row wraps up
    send_req(qubit_req(REQ_WRITE, LAYER_H,     4, 0, 1'b0, 1'b1));
    send_req(qubit_req(REQ_READ,  KIND_PLAQ,   4, 6, 1'b0, 1'b0));  // row wraps down
    send_req(qubit_req(REQ_WRITE, LAYER_V,     0, 3, 1'b0, 1'b1));
    send_req(qubit_req(REQ_READ,  KIND_PLAQ,   6, 3, 1'b0, 1'b0));  // column wraps right
    send_req(qubit_req(REQ_READ,  KIND_PLAQ,   0, 0, 1'b0, 1'b0));
    send_req(qubit_req(REQ_WRITE, LAYER_H,     7, 0, 1'b1, 1'b1));  // dropped write
    send_req(qubit_req(REQ_WRITE, LAYER_V,    31, 31, 1'b1, 1'b1)); // dropped write
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 31, 31, 1'b0, 1'b0)); // out of range
    send_req(qubit_req(REQ_READ,  KIND_PLAQ,   7, 3, 1'b0, 1'b0));
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 2, 7, 1'b0, 1'b0));
    send_req(qubit_req(REQ_WRITE, LAYER_H,     0, 0, 1'b0, 1'b0));  // clear again
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 0, 0, 1'b0, 1'b0));
    send_req(qubit_req(REQ_READ,  KIND_PLAQ,   0, 0, 1'b0, 1'b0));
    send_req(qubit_req(REQ_WRITE, LAYER_V,     6, 6, 1'b1, 1'b1));  // far corner
    send_req(qubit_req(REQ_READ,  KIND_PLAQ,   6, 6, 1'b0, 1'b0));
    send_req(qubit_req(REQ_READ,  KIND_VERTEX, 6, 6, 1'b0, 1'b0));

    // Random phases: sizes saturating low and high, then odd shapes; the
    // store is never cleared, so each resize reuses what earlier ones left.
    run_phase(32'd0,  32'd1,  0,  0,  150, 1'b0);
    run_phase(32'd63, 32'd33, 84, 0,  150, 1'b0);
    run_phase(32'd5,  32'd3,  0,  84, 150, 1'b1);
    run_phase(32'd2,  32'd32, 32, 32, 150, 1'b0);
    run_phase(32'd32, 32'd2,  0,  0,  150, 1'b0);
    for (int p = 0; p < 4; p++) begin
      run_phase($urandom_range(63), $urandom_range(63),
                (p == 1 || p == 3) ? ((p == 3) ? 32 : 84) : 0,
                (p == 2 || p == 3) ? ((p == 3) ? 32 : 84) : 0,
                140, p == 0);
    end

    rsp_stall_pct <= 0;
    drain();
    if (mismatches == 0) begin
      $display("tb_toric_code_syndrome_extraction: done, clean");
    end else begin
      $display("tb_toric_code_syndrome_extraction: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tcse_pkg.sv
rtl/toric_code_syndrome_extraction.sv
rtl/tcse_checker.sv
tb/tcse_syndrome_checker.sv
tb/tb_toric_code_syndrome_extraction.sv
